### hdl/pfe_pkg.sv
// Playfair encryptor package: command codes, letter constants and square
// index helpers. Depends on nothing; used by playfair_digraph_encrypt.
package pfe_pkg;

  // Command codes on cmd_i
  localparam logic [1:0] CMD_KEY   = 2'd0;
  localparam logic [1:0] CMD_SEAL  = 2'd1;
  localparam logic [1:0] CMD_PLAIN = 2'd2;
  localparam logic [1:0] CMD_END   = 2'd3;

  // Letters and sizes
  localparam logic [4:0] LETTER_I     = 5'd8;
  localparam logic [4:0] LETTER_J     = 5'd9;
  localparam logic [4:0] LETTER_X     = 5'd23;
  localparam logic [4:0] LETTER_LAST  = 5'd25;
  localparam logic [4:0] SQUARE_CELLS = 5'd25;
  localparam int         AlphabetLen  = 26;
  localparam int         SquareLen    = 25;

  // Row and column of a square cell
  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } cell_pos_t;

  // Split a cell index into row and column (divide by five by compare)
  function automatic cell_pos_t split_pos(input logic [4:0] idx);
    cell_pos_t rc;
    if (idx >= 5'd20) begin
      rc.row = 3'd4;
      rc.col = 3'(idx - 5'd20);
    end else if (idx >= 5'd15) begin
      rc.row = 3'd3;
      rc.col = 3'(idx - 5'd15);
    end else if (idx >= 5'd10) begin
      rc.row = 3'd2;
      rc.col = 3'(idx - 5'd10);
    end else if (idx >= 5'd5) begin
      rc.row = 3'd1;
      rc.col = 3'(idx - 5'd5);
    end else begin
      rc.row = 3'd0;
      rc.col = idx[2:0];
    end
    return rc;
  endfunction

  // Step one place along a row or column, wrapping at five
  function automatic logic [2:0] wrap_inc(input logic [2:0] v);
    return (v >= 3'd4) ? 3'd0 : 3'(v + 3'd1);
  endfunction

  // Cell index from row and column
  function automatic logic [4:0] join_pos(input logic [2:0] row, input logic [2:0] col);
    return 5'({2'b00, row} * 5'd5) + {2'b00, col};
  endfunction

endpackage

### hdl/pfe_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the key square and letter position stores.
module pfe_ram #(
  parameter int Width = 5,
  parameter int Depth = 25,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/playfair_digraph_encrypt.sv
// Playfair digraph encryptor top level: key square build, seal walk and
// pair encipherment. Depends on pfe_pkg and pfe_ram.
//
//   channel  dir  handshake               payload
//   input    in   in_valid_i/in_ready_o   cmd_i, letter_i
//   output   out  out_valid_o/out_ready_i cipher_letter_o, last_of_pair_o
//
// Key letters, plaintext letters without a pair and end with nothing held
// are finished when accepted. A seal is accepted, then walks over all 26
// letters, one a cycle. A digraph steps through S_POS_A, S_POS_B, S_CALC,
// S_OUT1, S_RD2 and S_OUT2, held by output stalls: two position reads and
// two cell reads share the single read port of each RAM.
// Reset clears the used flags, fill count, pending letter and control; the
// RAMs are not cleared. A full output register holds the sequencer.
module playfair_digraph_encrypt
  import pfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic [4:0] letter_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [4:0] cipher_letter_o,
  output logic       last_of_pair_o
);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SEAL  = 3'd1;
  localparam logic [2:0] S_POS_A = 3'd2;
  localparam logic [2:0] S_POS_B = 3'd3;
  localparam logic [2:0] S_CALC  = 3'd4;
  localparam logic [2:0] S_OUT1  = 3'd5;
  localparam logic [2:0] S_RD2   = 3'd6;
  localparam logic [2:0] S_OUT2  = 3'd7;

  logic [2:0]  state_q, state_d;
  logic [4:0]  fill_q, fill_d;
  logic [4:0]  walk_q, walk_d;
  logic [25:0] used_q, used_d;
  logic [4:0]  pend_q, pend_d;
  logic        pend_valid_q, pend_valid_d;
  logic [4:0]  a_q, a_d, b_q, b_d;
  logic [4:0]  pa_q, pa_d;
  logic [4:0]  idx1_q, idx1_d, idx2_q, idx2_d;
  logic        out_valid_q, out_valid_d;
  logic [4:0]  out_letter_q, out_letter_d;
  logic        out_last_q, out_last_d;

  logic        in_fire;
  logic        out_load;
  logic [4:0]  l_eff;
  logic        l_ok;
  logic [4:0]  place_letter;
  logic        place_try;
  logic        place_en;
  logic [4:0]  pos_raddr, pos_rdata;
  logic [4:0]  sq_raddr, sq_rdata;
  cell_pos_t   rc_a, rc_b;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = !out_valid_q || out_ready_i;

  // Fold J into I and reject letters past Z
  assign l_ok  = (letter_i <= LETTER_LAST);
  assign l_eff = (letter_i == LETTER_J) ? LETTER_I : letter_i;

  // Place a letter from the key stream or from the seal walk
  assign place_letter = (state_q == S_SEAL) ? walk_q : l_eff;
  assign place_try    = ((state_q == S_SEAL) && (walk_q != LETTER_J)) ||
                        (in_fire && (cmd_i == CMD_KEY) && l_ok);
  assign place_en     = place_try && !used_q[place_letter] && (fill_q < SQUARE_CELLS);

  // Key square: cell -> letter
  pfe_ram #(
    .Width(5),
    .Depth(SquareLen)
  ) u_square (
    .clk_i  (clk_i),
    .we_i   (place_en),
    .waddr_i(fill_q),
    .wdata_i(place_letter),
    .raddr_i(sq_raddr),
    .rdata_o(sq_rdata)
  );

  // Letter position: letter -> cell
  pfe_ram #(
    .Width(5),
    .Depth(AlphabetLen)
  ) u_position (
    .clk_i  (clk_i),
    .we_i   (place_en),
    .waddr_i(place_letter),
    .wdata_i(fill_q),
    .raddr_i(pos_raddr),
    .rdata_o(pos_rdata)
  );

  assign pos_raddr = (state_q == S_POS_A) ? a_q : b_q;

  // Work out the two cipher cells from the two positions
  always_comb begin
    rc_a = split_pos(pa_q);
    rc_b = split_pos(pos_rdata);
    if (rc_a.row == rc_b.row) begin
      idx1_d = join_pos(rc_a.row, wrap_inc(rc_a.col));
      idx2_d = join_pos(rc_b.row, wrap_inc(rc_b.col));
    end else if (rc_a.col == rc_b.col) begin
      idx1_d = join_pos(wrap_inc(rc_a.row), rc_a.col);
      idx2_d = join_pos(wrap_inc(rc_b.row), rc_b.col);
    end else begin
      idx1_d = join_pos(rc_a.row, rc_b.col);
      idx2_d = join_pos(rc_b.row, rc_a.col);
    end
  end

  // Square read address: first cell from the calculation, then held, then the second cell
  always_comb begin
    case (state_q)
      S_CALC:  sq_raddr = idx1_d;
      S_OUT1:  sq_raddr = idx1_q;
      default: sq_raddr = idx2_q;
    endcase
  end

  // Sequencer and pending-letter logic
  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    walk_d       = walk_q;
    used_d       = used_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    a_d          = a_q;
    b_d          = b_q;
    pa_d         = pa_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_letter_d = out_letter_q;
    out_last_d   = out_last_q;

    if (place_en) begin
      used_d[place_letter] = 1'b1;
      fill_d               = 5'(fill_q + 5'd1);
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (cmd_i)
            CMD_SEAL: begin
              pend_valid_d = 1'b0;
              walk_d       = 5'd0;
              state_d      = S_SEAL;
            end
            CMD_PLAIN: begin
              if (l_ok) begin
                if (!pend_valid_q) begin
                  pend_d       = l_eff;
                  pend_valid_d = 1'b1;
                end else if (pend_q == l_eff) begin
                  a_d     = l_eff;
                  b_d     = LETTER_X;
                  state_d = S_POS_A;
                end else begin
                  a_d          = pend_q;
                  b_d          = l_eff;
                  pend_valid_d = 1'b0;
                  state_d      = S_POS_A;
                end
              end
            end
            CMD_END: begin
              if (pend_valid_q) begin
                a_d          = pend_q;
                b_d          = LETTER_X;
                pend_valid_d = 1'b0;
                state_d      = S_POS_A;
              end
            end
            default: ;
          endcase
        end
      end
      S_SEAL: begin
        walk_d = 5'(walk_q + 5'd1);
        if (walk_q == LETTER_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_POS_A: state_d = S_POS_B;
      S_POS_B: begin
        pa_d    = pos_rdata;
        state_d = S_CALC;
      end
      S_CALC: state_d = S_OUT1;
      S_OUT1: begin
        if (out_load) begin
          out_valid_d  = 1'b1;
          out_letter_d = sq_rdata;
          out_last_d   = 1'b0;
          state_d      = S_RD2;
        end
      end
      S_RD2: state_d = S_OUT2;
      S_OUT2: begin
        if (out_load) begin
          out_valid_d  = 1'b1;
          out_letter_d = sq_rdata;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fill_q       <= 5'd0;
      walk_q       <= 5'd0;
      used_q       <= '0;
      pend_q       <= 5'd0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      walk_q       <= walk_d;
      used_q       <= used_d;
      pend_q       <= pend_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    a_q          <= a_d;
    b_q          <= b_d;
    pa_q         <= pa_d;
    out_letter_q <= out_letter_d;
    out_last_q   <= out_last_d;
    if (state_q == S_CALC) begin
      idx1_q <= idx1_d;
      idx2_q <= idx2_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cipher_letter_o = out_letter_q;
  assign last_of_pair_o  = out_last_q;

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= SQUARE_CELLS)
    else $error("fill count past square size");

  a_seal_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEAL && walk_q == LETTER_LAST) |=> (fill_q == SQUARE_CELLS))
    else $error("square not full after seal");

  a_seal_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cmd_i == CMD_SEAL) |=> !pend_valid_q)
    else $error("pending letter survived seal");

  a_second_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT2 && out_load) |=> (out_valid_o && last_of_pair_o && in_ready_o))
    else $error("second beat of digraph not presented");

endmodule
